/* rtl/core/shs_pkg.sv */
package shs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } shs_state_t;

  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_MARK,
    SEL_ZERO,
    SEL_LENGTH
  } byte_sel_t;

  typedef struct packed {
    logic        shift_byte;
    byte_sel_t   byte_sel;
    logic        count_bits;
    logic        load_vars;
    logic        do_round;
    logic [5:0]  round;
    logic        add_chain;
    logic        restart;
    logic [2:0]  word_idx;
  } shs_cmd_t;

  typedef struct packed {
    logic fill_last;  // next byte completes the block
    logic len_zone;   // fill is in the length field (56..63)
  } shs_status_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

/* rtl/core/shs_in_if.sv */
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input end_of_message, output ready);
endinterface

/* rtl/core/shs_out_if.sv */
interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source (output valid, output digest_word, output word_number,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_number,
                input last_word, output ready);
endinterface

/* rtl/core/shs_datapath.sv */
module shs_datapath
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  shs_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  output shs_status_t status,
  output logic [31:0] digest_word
);

  logic [31:0] w [16];       // block buffer, doubles as the message schedule
  logic [31:0] chain [8];
  logic [31:0] vars [8];     // a..h
  logic [63:0] msg_bits;
  logic [5:0]  fill;

  logic [7:0]  new_byte;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    unique case (cmd.byte_sel)
      SEL_INPUT:  new_byte = data_byte;
      SEL_MARK:   new_byte = PAD_MARK;
      SEL_ZERO:   new_byte = 8'd0;
      SEL_LENGTH: new_byte = msg_bits[{~fill[2:0], 3'b000} +: 8];
      default:    new_byte = 8'd0;
    endcase
  end

  assign w_new = w[0] + small_sigma0(w[1]) + w[9] + small_sigma1(w[14]);
  assign ch    = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj   = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1    = vars[7] + big_sigma1(vars[4]) + ch + ROUND_K[cmd.round] + w[0];
  assign t2    = big_sigma0(vars[0]) + maj;

  assign status.fill_last = (fill == 6'd63);
  assign status.len_zone  = (fill[5:3] == 3'd7);
  assign digest_word      = chain[cmd.word_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      msg_bits <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= H_INIT[i];
    end else begin
      if (cmd.shift_byte) fill <= fill + 6'd1;
      if (cmd.count_bits) msg_bits <= msg_bits + 64'd8;
      if (cmd.add_chain) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
      end
      if (cmd.restart) begin
        msg_bits <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= H_INIT[i];
      end
    end
  end

  // bytes enter big-endian at the bottom of the 512-bit buffer
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i+1][31:24]};
      w[15] <= {w[15][23:0], new_byte};
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) vars[i] <= chain[i];
    end else if (cmd.do_round) begin
      vars[0] <= t1 + t2;
      vars[1] <= vars[0];
      vars[2] <= vars[1];
      vars[3] <= vars[2];
      vars[4] <= vars[3] + t1;
      vars[5] <= vars[4];
      vars[6] <= vars[5];
      vars[7] <= vars[6];
    end
  end

endmodule

/* rtl/core/shs_ctrl.sv */
module shs_ctrl
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  shs_status_t status,
  output shs_cmd_t    cmd
);

  shs_state_t state;
  shs_state_t state_next;
  logic [5:0] round;
  logic [2:0] word_idx;
  logic       pad_active;
  logic       mark_pend;
  logic       len_ok;
  logic       final_block;
  logic       in_acc;
  logic       out_acc;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && byte_present && status.fill_last) state_next = ST_LOAD;
        else if (in_acc && end_of_message) state_next = ST_PAD;
      end
      ST_PAD: begin
        if (status.fill_last) state_next = ST_LOAD;
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (round == LAST_ROUND) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (final_block) state_next = ST_OUT;
        else if (pad_active) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_OUT: begin
        if (out_acc && word_idx == LAST_WORD_IDX) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.byte_sel   = SEL_INPUT;
    cmd.round      = round;
    cmd.word_idx   = word_idx;
    unique case (state)
      ST_IDLE: begin
        cmd.shift_byte = in_acc && byte_present;
        cmd.count_bits = in_acc && byte_present;
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        if (mark_pend) cmd.byte_sel = SEL_MARK;
        else if (len_ok && status.len_zone) cmd.byte_sel = SEL_LENGTH;
        else cmd.byte_sel = SEL_ZERO;
      end
      ST_LOAD:  cmd.load_vars = 1'b1;
      ST_ROUND: cmd.do_round = 1'b1;
      ST_FINAL: cmd.add_chain = 1'b1;
      ST_OUT:   cmd.restart = out_acc && (word_idx == LAST_WORD_IDX);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round       <= '0;
      word_idx    <= '0;
      pad_active  <= 1'b0;
      mark_pend   <= 1'b0;
      len_ok      <= 1'b0;
      final_block <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) round <= '0;
      else if (state == ST_ROUND) round <= round + 6'd1;
      if (out_acc) word_idx <= word_idx + 3'd1;
      if (in_acc && end_of_message) begin
        pad_active  <= 1'b1;
        mark_pend   <= 1'b1;
        len_ok      <= 1'b0;
        final_block <= 1'b0;
      end
      if (state == ST_PAD) begin
        mark_pend <= 1'b0;
        // mark landed early enough that the length fits in this block
        if (mark_pend && !status.len_zone) len_ok <= 1'b1;
        if (!mark_pend && len_ok && status.len_zone && status.fill_last)
          final_block <= 1'b1;
      end
      if (state == ST_FINAL && pad_active) len_ok <= 1'b1;
      if (cmd.restart) begin
        pad_active  <= 1'b0;
        final_block <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_xor_valid: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while digest pending");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == LAST_ROUND) |=> state == ST_FINAL)
    else $error("compression did not finish after last round");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(word_idx)))
    else $error("digest word index moved under stall");

  a_block_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_byte && status.fill_last) |=> state == ST_LOAD)
    else $error("full block not compressed");

  a_final_in_pad: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (pad_active && final_block))
    else $error("digest emitted outside padding");
`endif

endmodule

/* rtl/core/sha256_stream_hasher_top.sv */
// SHA-256 over a byte stream.
// data_in: one item per handshake; data_byte is taken when byte_present is
//   set, end_of_message closes the message after that item's byte.
// digest: eight items per message, word 0 (most significant) first,
//   last_word marks word 7.
// One byte is taken per cycle while data_in.ready is high. Each 64th byte
//   of the message starts a compression that holds ready low through its
//   load, 64 rounds of the single round unit, and chain update.
// After end_of_message the block writes pad bytes itself, one per cycle
//   outside compressions, 64 - f bytes when f <= 55 bytes are buffered, else
//   128 - f; the first digest word is valid in the cycle right after the
//   chain update of the last compression.
// While words wait, data_in.ready stays low; a stalled digest word holds
//   until taken. After word 7 is taken the chaining state returns to the
//   initial hash values and the block accepts the next message.
// rst (synchronous) drops any partial message and restores the initial
//   hash values.
module sha256_stream_hasher_top
  import shs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  shs_in_if.sink    data_in,
  shs_out_if.source digest
);

  shs_cmd_t    cmd;
  shs_status_t status;

  shs_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (data_in.valid),
    .byte_present   (data_in.byte_present),
    .end_of_message (data_in.end_of_message),
    .in_ready       (data_in.ready),
    .out_valid      (digest.valid),
    .out_ready      (digest.ready),
    .status         (status),
    .cmd            (cmd)
  );

  shs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_in.data_byte),
    .status      (status),
    .digest_word (digest.digest_word)
  );

  assign digest.word_number = cmd.word_idx;
  assign digest.last_word   = (cmd.word_idx == LAST_WORD_IDX);

endmodule

/* tb/sha256_stream_hasher_checker.sv */
`timescale 1ns / 1ps

module sha256_stream_hasher_checker (
  input  logic clk,
  input  logic rst,
  shs_in_if    data_in,
  shs_out_if   digest,
  output int   fail_count,
  output int   words_pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  number;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] MARK_BYTE = 8'h80;
  localparam int BLOCK_BYTES = 64;
  localparam int LEN_FIELD_AT = 56;
  localparam logic [2:0] LAST_NUMBER = 3'd7;

  logic [31:0]  chain_h [8];
  logic [7:0]   block_buf [BLOCK_BYTES];
  int           fill_cnt;
  logic [63:0]  bit_len;
  digest_word_t expected_words [$];

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void start_message();
    for (int i = 0; i < 8; i++) chain_h[i] = IV[i];
    fill_cnt = 0;
    bit_len = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] x, y, wr, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        // rolling 16-entry schedule
        x = w[(r + 1) % 16];
        y = w[(r + 14) % 16];
        wr = w[r % 16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[(r + 9) % 16]
             + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        w[r % 16] = wr;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + wr;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void hash_item(input logic [7:0] b, input logic p, input logic e);
    digest_word_t dw;
    if (p) begin
      block_buf[fill_cnt] = b;
      fill_cnt++;
      bit_len = bit_len + 64'd8;
      if (fill_cnt == BLOCK_BYTES) begin
        compress_block();
        fill_cnt = 0;
      end
    end
    if (e) begin
      block_buf[fill_cnt] = MARK_BYTE;
      fill_cnt++;
      // no room left for the length field: pad out and take an extra block
      if (fill_cnt > LEN_FIELD_AT) begin
        for (int i = fill_cnt; i < BLOCK_BYTES; i++) block_buf[i] = 8'h00;
        compress_block();
        fill_cnt = 0;
      end
      for (int i = fill_cnt; i < LEN_FIELD_AT; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_buf[BLOCK_BYTES - 1 - i] = bit_len[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain_h[i];
        dw.number = 3'(i);
        dw.last = (3'(i) == LAST_NUMBER);
        expected_words = {expected_words, dw};
      end
      start_message();
    end
  endfunction

  always @(posedge clk) begin
    digest_word_t want;
    if (rst) begin
      start_message();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (digest.valid && digest.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest item: expected none, got word %h number %0d last %b",
                   $time, digest.digest_word, digest.word_number, digest.last_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (digest.digest_word !== want.word) begin
            $display("%0t: digest_word mismatch: expected %h, got %h",
                     $time, want.word, digest.digest_word);
            fail_count++;
          end
          if (digest.word_number !== want.number) begin
            $display("%0t: word_number mismatch: expected %0d, got %0d",
                     $time, want.number, digest.word_number);
            fail_count++;
          end
          if (digest.last_word !== want.last) begin
            $display("%0t: last_word mismatch: expected %b, got %b",
                     $time, want.last, digest.last_word);
            fail_count++;
          end
        end
      end
      if (data_in.valid && data_in.ready)
        hash_item(data_in.data_byte, data_in.byte_present, data_in.end_of_message);
    end
    words_pending = expected_words.size();
  end

endmodule

/* tb/sha256_stream_hasher_top_tb.sv */
`timescale 1ns / 1ps

module sha256_stream_hasher_top_tb;

  localparam int ITEM_TARGET = 410;
  localparam int CALM_FROM = 350;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   words_pending;
  int   idle_cycles = 0;
  int   item_count = 0;
  int   gap_rate = 0;
  bit   calm = 1'b0;

  shs_in_if  data_in ();
  shs_out_if digest ();

  sha256_stream_hasher_top dut (
    .clk     (clk),
    .rst     (rst),
    .data_in (data_in),
    .digest  (digest)
  );

  sha256_stream_hasher_checker hash_check (
    .clk           (clk),
    .rst           (rst),
    .data_in       (data_in),
    .digest        (digest),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #4 clk = ~clk;

  // watchdog: any cycle without a handshake on either channel counts
  always @(posedge clk) begin
    if (rst || (data_in.valid && data_in.ready) || (digest.valid && digest.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sha256_stream_hasher_top verification failed");
      $finish;
    end
  end

  // digest receiver: stall bursts between stretches of ready, always ready once calm
  initial begin
    forever begin
      if (calm) begin
        digest.ready <= 1'b1;
        @(posedge clk);
      end else begin
        digest.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        digest.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic pause_maybe();
    if (!calm && gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
      data_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // valid stays high into the next item unless a pause lowers it
  task automatic send_item(input logic [7:0] b, input logic p, input logic e);
    pause_maybe();
    data_in.valid          <= 1'b1;
    data_in.data_byte      <= b;
    data_in.byte_present   <= p;
    data_in.end_of_message <= e;
    @(posedge clk);
    while (!data_in.ready) @(posedge clk);
    if (p || e) item_count++;
  endtask

  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int sel;
    rst                    <= 1'b1;
    data_in.valid          <= 1'b0;
    data_in.data_byte      <= 8'h00;
    data_in.byte_present   <= 1'b0;
    data_in.end_of_message <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty message, an ignored item, then "abc" closed on its last byte
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    gap_rate = 30;
    // closed by an item without a byte
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hc3, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);

    // mostly short messages, some around one block and a few near two
    while (item_count < ITEM_TARGET) begin
      if (item_count >= CALM_FROM) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: gap_rate = 0;
        1: gap_rate = 10;
        default: gap_rate = 40;
      endcase
      sel = $urandom_range(0, 9);
      if (sel < 6) len = $urandom_range(0, 10);
      else if (sel < 9) len = $urandom_range(50, 72);
      else len = $urandom_range(112, 130);
      send_message(len, 1'($urandom_range(0, 1)));
    end
    data_in.valid <= 1'b0;

    do @(posedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("sha256_stream_hasher_top verification clean");
    end else begin
      $display("sha256_stream_hasher_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/shs_pkg.sv
rtl/core/shs_in_if.sv
rtl/core/shs_out_if.sv
rtl/core/shs_datapath.sv
rtl/core/shs_ctrl.sv
rtl/core/sha256_stream_hasher_top.sv
tb/sha256_stream_hasher_checker.sv
tb/sha256_stream_hasher_top_tb.sv
